### src/bba_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package bba_pkg;

	localparam int HEADER_BYTES = 16;
	localparam int UNIT_LOG     = 5;
	localparam int UNIT_W       = 15;
	localparam int LINK_W       = 16;
	localparam int ORD_W        = 5;
	localparam int ORDER_SLOTS  = 21;
	localparam int POOL_W       = 21;
	localparam int ADDR_W       = 21;

	localparam logic [LINK_W-1:0] LINK_NONE = 16'hFFFF;
	localparam logic [ORD_W-1:0]  MAX_ORD   = 5'd20;
	localparam logic [ORD_W-1:0]  SLOT_END  = 5'd21;
	localparam logic [POOL_W-1:0] POOL_MAX  = 21'h100000;

	localparam logic MODE_ALLOC = 1'b0;
	localparam logic MODE_FREE  = 1'b1;

	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_FAIL   = 2'd1;
	localparam logic [1:0] ST_REJECT = 2'd2;

	typedef struct packed {
		logic              hd;
		logic              fr;
		logic [ORD_W-1:0]  ord;
		logic [LINK_W-1:0] nx;
		logic [LINK_W-1:0] pv;
	} unit_t;

	typedef struct packed {
		logic              mode;
		logic [POOL_W-1:0] req_bytes;
		logic [ADDR_W-1:0] ptr;
	} req_t;

	typedef struct packed {
		logic [1:0]        status;
		logic [19:0]       granted;
		logic [POOL_W-1:0] usable;
		logic [POOL_W-1:0] reserved;
	} res_t;

	localparam unit_t UNIT_BLANK = '{hd: 1'b0, fr: 1'b0, ord: '0, nx: LINK_NONE, pv: LINK_NONE};

endpackage
`default_nettype wire

### src/buddy_block_allocator.sv
`timescale 1ns / 1ps
`default_nettype none
// Channel   Direction  Handshake          Payload
// s_*       in         s_tvalid/s_tready  tuser: mode; tdata: request_bytes, payload_offset
// m_*       out        m_tvalid/m_tready  tuser: status; tdata: granted_offset, usable_bytes,
//                                         reserved_total
// cfg_*     in         cfg_we             cfg_wdata: pool_bytes
//
// One item is worked at a time by a sequencer around a single-port unit memory with a
// registered read; every list push or unlink is a series of read-modify-write steps.
// An allocate sizes the request, scans upward past empty orders and splits a larger block
// down to size; a free checks the header, then merges with free buddies order by order.
// After reset and after each pool_bytes write a clearing pass writes all 32768 unit entries,
// one per cycle, then carving pushes each block; no item is accepted meanwhile. The result
// register lets the next item enter while a result waits.
module buddy_block_allocator
	import bba_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_we,
	input  wire logic [POOL_W-1:0] cfg_wdata,   // pool_bytes
	input  wire logic              s_tvalid,
	output logic                   s_tready,
	input  wire logic [47:0]       s_tdata,     // request_bytes[20:0], payload_offset[41:21]
	input  wire logic [0:0]        s_tuser,     // mode
	output logic                   m_tvalid,
	input  wire logic              m_tready,
	output logic [63:0]            m_tdata,     // granted_offset[19:0], usable_bytes[40:20],
	                                            // reserved_total[61:41]
	output logic [1:0]             m_tuser      // status
);

	logic ctrl_idle, ctrl_done, take;
	req_t req;
	res_t res;
	res_t out_q;
	logic out_valid_q;

	// Request fields as they arrive; the sequencer latches what it needs.
	assign req = '{mode: s_tuser[0], req_bytes: s_tdata[20:0], ptr: s_tdata[41:21]};
	assign s_tready = ctrl_idle;

	bba_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.start     (s_tvalid & ctrl_idle),
		.req       (req),
		.idle      (ctrl_idle),
		.done      (ctrl_done),
		.done_ack  (take),
		.res       (res)
	);

	// The finished result moves into the output register once it is free or being drained.
	assign take = ctrl_done && (!out_valid_q || m_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (take) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			out_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser = out_q.status;
	assign m_tdata = {2'b00, out_q.reserved, out_q.usable, out_q.granted};

endmodule
`default_nettype wire

### src/bba_mem.sv
`timescale 1ns / 1ps
`default_nettype none
module bba_mem
	import bba_pkg::*;
(
	input  wire logic              clk,
	input  wire logic [UNIT_W-1:0] addr,
	input  wire logic              we,
	input  wire unit_t             wdata,
	output unit_t                  rdata
);

	// One entry per 32-byte unit of the pool, single port, registered read.
	unit_t mem [2**UNIT_W];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule
`default_nettype wire

### src/bba_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module bba_ctrl
	import bba_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_we,
	input  wire logic [POOL_W-1:0] cfg_wdata,
	input  wire logic              start,
	input  wire req_t              req,
	output logic                   idle,
	output logic                   done,
	input  wire logic              done_ack,
	output res_t                   res
);

	localparam logic [4:0] S_IDLE    = 5'd0;
	localparam logic [4:0] S_CLR     = 5'd1;
	localparam logic [4:0] S_CSTART  = 5'd2;
	localparam logic [4:0] S_CSRCH   = 5'd3;
	localparam logic [4:0] S_CNEXT   = 5'd4;
	localparam logic [4:0] S_ASIZE   = 5'd5;
	localparam logic [4:0] S_ASCAN   = 5'd6;
	localparam logic [4:0] S_ASPLIT  = 5'd7;
	localparam logic [4:0] S_AHALF   = 5'd8;
	localparam logic [4:0] S_APUSHA  = 5'd9;
	localparam logic [4:0] S_ATAKE   = 5'd10;
	localparam logic [4:0] S_AGRANT  = 5'd11;
	localparam logic [4:0] S_FREAD   = 5'd12;
	localparam logic [4:0] S_FCHECK  = 5'd13;
	localparam logic [4:0] S_MTEST   = 5'd14;
	localparam logic [4:0] S_MLOOK   = 5'd15;
	localparam logic [4:0] S_MMERGE  = 5'd16;
	localparam logic [4:0] S_FPUSH   = 5'd17;
	localparam logic [4:0] S_DONE    = 5'd18;
	localparam logic [4:0] S_P0      = 5'd19;
	localparam logic [4:0] S_P1      = 5'd20;
	localparam logic [4:0] S_P2      = 5'd21;
	localparam logic [4:0] S_R0      = 5'd22;
	localparam logic [4:0] S_R1      = 5'd23;
	localparam logic [4:0] S_R2      = 5'd24;
	localparam logic [4:0] S_R3      = 5'd25;
	localparam logic [4:0] S_R4      = 5'd26;
	localparam logic [4:0] S_R5      = 5'd27;

	logic [4:0]        st_q, ret_q;
	logic [POOL_W-1:0] pool_q, used_q, resv_q, req_q;
	logic [UNIT_W-1:0] clr_q;
	logic [LINK_W-1:0] head_q [ORDER_SLOTS];
	logic [15:0]       cnt_q  [ORDER_SLOTS];
	logic [ORD_W-1:0]  n_q, m_q, k_q, so_q;
	logic [LINK_W-1:0] a_q, u_q, bu_q, su_q, hq_q;
	logic              bo_lt_q;
	logic [1:0]        afl_q;
	unit_t             e_q;
	logic [6:0]        sent_q;
	res_t              res_q;

	logic [UNIT_W-1:0] mem_addr;
	logic              mem_we;
	unit_t             mem_wd, rd;

	bba_mem u_mem (
		.clk   (clk),
		.addr  (mem_addr),
		.we    (mem_we),
		.wdata (mem_wd),
		.rdata (rd)
	);

	// Per-order list state, read at one order index at a time.
	logic [ORD_W-1:0]  lidx;
	logic [LINK_W-1:0] lhead;
	logic [15:0]       lcnt;
	logic              link_ok;

	assign lidx = (st_q == S_ASCAN || st_q == S_ASPLIT || st_q == S_ATAKE) ? m_q : so_q;
	assign lhead = head_q[lidx];
	assign lcnt = cnt_q[lidx];
	assign link_ok = (lcnt != 16'd0) && !lhead[LINK_W-1];

	// Allocate sizing and split arithmetic.
	logic [21:0] need_w;
	logic [22:0] pow_n;
	logic        size_more;
	logic [ORD_W-1:0] msub;
	logic [16:0] b_w;
	assign need_w = {1'b0, req_q} + 22'(HEADER_BYTES);
	assign pow_n = 23'(1) << n_q;
	assign size_more = (n_q < 5'd22) && (pow_n < {1'b0, need_w});
	assign msub = m_q - 5'd1;
	assign b_w = {1'b0, a_q} + (17'(1) << (msub - 5'(UNIT_LOG)));

	// Buddy address arithmetic.
	logic [21:0] here_w, s_w, up_w, dn_w, bo_w;
	logic        mtest_stop;
	assign here_w = {2'b00, u_q[UNIT_W-1:0], 5'b00000};
	assign s_w = 22'(1) << k_q;
	assign up_w = here_w + s_w;
	assign dn_w = here_w - s_w;
	assign bo_w = here_w[k_q] ? dn_w : up_w;
	assign mtest_stop = (k_q >= MAX_ORD) ||
		(!here_w[k_q] && ((up_w + s_w) > {1'b0, pool_q})) ||
		(here_w[k_q] && (here_w < s_w)) ||
		(bo_w[21:20] != 2'b00);

	logic [POOL_W-1:0] sz_w, rest_w;
	assign sz_w = 21'(1) << rd.ord;
	assign rest_w = pool_q - used_q;

	logic ptr_bad;
	assign ptr_bad = (req.ptr >= pool_q) || (req.ptr < 21'(HEADER_BYTES)) ||
		(req.ptr[4:0] != 5'd16);

	always_comb begin
		mem_addr = su_q[UNIT_W-1:0];
		mem_we = 1'b0;
		mem_wd = UNIT_BLANK;
		case (st_q)
			S_CLR: begin
				mem_addr = clr_q;
				mem_we = 1'b1;
			end
			S_P0: begin
				mem_we = 1'b1;
				mem_wd = '{hd: sent_q[6], fr: sent_q[5], ord: sent_q[4:0],
					nx: link_ok ? lhead : LINK_NONE, pv: LINK_NONE};
			end
			S_P1: mem_addr = hq_q[UNIT_W-1:0];
			S_P2: begin
				mem_addr = hq_q[UNIT_W-1:0];
				mem_we = 1'b1;
				mem_wd = rd;
				mem_wd.pv = su_q;
			end
			S_R1: begin
				mem_we = 1'b1;
				mem_wd = rd;
				mem_wd.nx = LINK_NONE;
				mem_wd.pv = LINK_NONE;
			end
			S_R2: mem_addr = e_q.pv[UNIT_W-1:0];
			S_R3: begin
				mem_addr = e_q.pv[UNIT_W-1:0];
				mem_we = 1'b1;
				mem_wd = rd;
				mem_wd.nx = e_q.nx;
			end
			S_R4: mem_addr = e_q.nx[UNIT_W-1:0];
			S_R5: begin
				mem_addr = e_q.nx[UNIT_W-1:0];
				mem_we = 1'b1;
				mem_wd = rd;
				mem_wd.pv = e_q.pv;
			end
			S_FREAD: mem_addr = u_q[UNIT_W-1:0];
			S_MTEST: mem_addr = bo_w[19:5];
			S_MMERGE: begin
				mem_addr = bo_lt_q ? u_q[UNIT_W-1:0] : bu_q[UNIT_W-1:0];
				mem_we = 1'b1;
			end
			S_AGRANT: begin
				mem_addr = u_q[UNIT_W-1:0];
				mem_we = 1'b1;
				mem_wd = '{hd: e_q.hd, fr: 1'b0, ord: e_q.ord, nx: LINK_NONE, pv: LINK_NONE};
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_CLR;
			ret_q <= S_IDLE;
			pool_q <= POOL_MAX;
			used_q <= '0;
			resv_q <= '0;
			clr_q <= '0;
			for (int i = 0; i < ORDER_SLOTS; i++) begin
				head_q[i] <= LINK_NONE;
				cnt_q[i] <= '0;
			end
		end else if (cfg_we) begin
			st_q <= S_CLR;
			pool_q <= (cfg_wdata > POOL_MAX) ? POOL_MAX : cfg_wdata;
			used_q <= '0;
			resv_q <= '0;
			clr_q <= '0;
			for (int i = 0; i < ORDER_SLOTS; i++) begin
				head_q[i] <= LINK_NONE;
				cnt_q[i] <= '0;
			end
		end else begin
			case (st_q)
				S_IDLE: begin
					if (start) begin
						req_q <= req.req_bytes;
						if (req.mode == MODE_ALLOC) begin
							n_q <= 5'(UNIT_LOG);
							st_q <= S_ASIZE;
						end else if (ptr_bad) begin
							res_q <= '{status: ST_REJECT, granted: '0, usable: '0, reserved: resv_q};
							st_q <= S_DONE;
						end else begin
							u_q <= {1'b0, req.ptr[19:5]};
							st_q <= S_FREAD;
						end
					end
				end
				S_CLR: begin
					clr_q <= clr_q + 15'd1;
					if (clr_q == '1) begin
						st_q <= S_CSTART;
					end
				end
				S_CSTART: begin
					if (rest_w >= 21'd32) begin
						k_q <= '0;
						st_q <= S_CSRCH;
					end else begin
						resv_q <= '0;
						st_q <= S_IDLE;
					end
				end
				S_CSRCH: begin
					if (k_q < MAX_ORD && (21'(1) << (k_q + 5'd1)) <= rest_w) begin
						k_q <= k_q + 5'd1;
					end else begin
						so_q <= k_q;
						su_q <= {1'b0, used_q[19:5]};
						sent_q <= {2'b11, k_q};
						ret_q <= S_CNEXT;
						st_q <= S_P0;
					end
				end
				S_CNEXT: begin
					used_q <= used_q + (21'(1) << k_q);
					st_q <= S_CSTART;
				end
				S_ASIZE: begin
					if (size_more) begin
						n_q <= n_q + 5'd1;
					end else if (n_q >= SLOT_END) begin
						res_q <= '{status: ST_FAIL, granted: '0, usable: '0, reserved: resv_q};
						st_q <= S_DONE;
					end else begin
						m_q <= n_q;
						st_q <= S_ASCAN;
					end
				end
				S_ASCAN: begin
					if (m_q == SLOT_END) begin
						res_q <= '{status: ST_FAIL, granted: '0, usable: '0, reserved: resv_q};
						st_q <= S_DONE;
					end else if (lcnt == 16'd0) begin
						m_q <= m_q + 5'd1;
					end else begin
						st_q <= S_ASPLIT;
					end
				end
				S_ASPLIT: begin
					if (m_q == n_q) begin
						st_q <= S_ATAKE;
					end else if (lhead[LINK_W-1]) begin
						res_q <= '{status: ST_FAIL, granted: '0, usable: '0, reserved: resv_q};
						st_q <= S_DONE;
					end else begin
						a_q <= lhead;
						so_q <= m_q;
						su_q <= lhead;
						ret_q <= S_AHALF;
						st_q <= S_R0;
					end
				end
				S_AHALF: begin
					afl_q <= {e_q.hd, e_q.fr};
					m_q <= msub;
					if (b_w[16:15] == 2'b00) begin
						so_q <= msub;
						su_q <= b_w[15:0];
						sent_q <= {2'b11, msub};
						ret_q <= S_APUSHA;
						st_q <= S_P0;
					end else begin
						st_q <= S_APUSHA;
					end
				end
				S_APUSHA: begin
					so_q <= m_q;
					su_q <= a_q;
					sent_q <= {afl_q, m_q};
					ret_q <= S_ASPLIT;
					st_q <= S_P0;
				end
				S_ATAKE: begin
					if (lhead[LINK_W-1]) begin
						res_q <= '{status: ST_FAIL, granted: '0, usable: '0, reserved: resv_q};
						st_q <= S_DONE;
					end else begin
						u_q <= lhead;
						so_q <= n_q;
						su_q <= lhead;
						ret_q <= S_AGRANT;
						st_q <= S_R0;
					end
				end
				S_AGRANT: begin
					resv_q <= resv_q + (21'(1) << n_q);
					res_q <= '{status: ST_OK, granted: {u_q[UNIT_W-1:0], 5'd16},
						usable: (21'(1) << n_q) - 21'(HEADER_BYTES),
						reserved: resv_q + (21'(1) << n_q)};
					st_q <= S_DONE;
				end
				S_FREAD: st_q <= S_FCHECK;
				S_FCHECK: begin
					if (!rd.hd || rd.fr || rd.ord >= SLOT_END) begin
						res_q <= '{status: ST_REJECT, granted: '0, usable: '0, reserved: resv_q};
						st_q <= S_DONE;
					end else begin
						k_q <= rd.ord;
						resv_q <= (resv_q >= sz_w) ? resv_q - sz_w : '0;
						st_q <= S_MTEST;
					end
				end
				S_MTEST: begin
					if (mtest_stop) begin
						st_q <= S_FPUSH;
					end else begin
						bo_lt_q <= here_w[k_q];
						bu_q <= {1'b0, bo_w[19:5]};
						st_q <= S_MLOOK;
					end
				end
				S_MLOOK: begin
					if (!rd.hd || !rd.fr || rd.ord != k_q) begin
						st_q <= S_FPUSH;
					end else begin
						so_q <= k_q;
						su_q <= bu_q;
						ret_q <= S_MMERGE;
						st_q <= S_R0;
					end
				end
				S_MMERGE: begin
					if (bo_lt_q) begin
						u_q <= bu_q;
					end
					k_q <= k_q + 5'd1;
					st_q <= S_MTEST;
				end
				S_FPUSH: begin
					so_q <= k_q;
					su_q <= u_q;
					sent_q <= {2'b11, k_q};
					res_q <= '{status: ST_OK, granted: '0, usable: '0, reserved: resv_q};
					ret_q <= S_DONE;
					st_q <= S_P0;
				end
				S_DONE: begin
					if (done_ack) begin
						st_q <= S_IDLE;
					end
				end
				S_P0: begin
					hq_q <= lhead;
					head_q[so_q] <= su_q;
					cnt_q[so_q] <= lcnt + 16'd1;
					st_q <= link_ok ? S_P1 : ret_q;
				end
				S_P1: st_q <= S_P2;
				S_P2: st_q <= ret_q;
				S_R0: st_q <= S_R1;
				S_R1: begin
					e_q <= rd;
					if (lcnt != 16'd0) begin
						cnt_q[so_q] <= lcnt - 16'd1;
					end
					if (rd.pv[LINK_W-1]) begin
						head_q[so_q] <= rd.nx;
					end
					st_q <= S_R2;
				end
				S_R2: st_q <= e_q.pv[LINK_W-1] ? S_R4 : S_R3;
				S_R3: st_q <= S_R4;
				S_R4: st_q <= e_q.nx[LINK_W-1] ? ret_q : S_R5;
				S_R5: st_q <= ret_q;
				default: st_q <= S_IDLE;
			endcase
		end
	end

	assign idle = (st_q == S_IDLE);
	assign done = (st_q == S_DONE);
	assign res = res_q;

endmodule
`default_nettype wire

### tb/sv/bba_checker.sv
`timescale 1ns / 1ps
module bba_checker
	import bba_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_we,
	input  wire logic [POOL_W-1:0] cfg_wdata,
	input  wire logic              s_tvalid,
	input  wire logic              s_tready,
	input  wire logic [47:0]       s_tdata,
	input  wire logic [0:0]        s_tuser,
	input  wire logic              m_tvalid,
	input  wire logic              m_tready,
	input  wire logic [63:0]       m_tdata,
	input  wire logic [1:0]        m_tuser,
	output int                     pending,
	output int                     failures
);

	localparam int UNITS = 32768;
	localparam int NONE  = 32'hFFFF;

	int     blk_ord [UNITS];
	bit     blk_free[UNITS];
	bit     blk_head[UNITS];
	int     nxt     [UNITS];
	int     prv     [UNITS];
	int     list_top[ORDER_SLOTS];
	int     list_len[ORDER_SLOTS];
	longint held_bytes;
	longint pool_size;
	res_t   awaited[$];

	function automatic void push_free(int k, int u);
		prv[u] = NONE;
		if (list_len[k] > 0 && list_top[k] < UNITS) begin
			nxt[u] = list_top[k];
			prv[list_top[k]] = u;
		end else begin
			nxt[u] = NONE;
		end
		list_top[k] = u;
		list_len[k]++;
	endfunction

	function automatic void unlink(int k, int u);
		int p;
		int n;
		p = prv[u];
		n = nxt[u];
		if (p < UNITS) nxt[p] = n;
		else list_top[k] = n;
		if (n < UNITS) prv[n] = p;
		if (list_len[k] > 0) list_len[k]--;
		nxt[u] = NONE;
		prv[u] = NONE;
	endfunction

	// Lays the pool out as descending power-of-two free blocks.
	function automatic void recarve();
		longint used;
		longint rest;
		int i;
		used = 0;
		for (int u = 0; u < UNITS; u++) begin
			blk_ord[u] = 0; blk_free[u] = 0; blk_head[u] = 0;
			nxt[u] = NONE; prv[u] = NONE;
		end
		for (int k = 0; k < ORDER_SLOTS; k++) begin
			list_top[k] = NONE;
			list_len[k] = 0;
		end
		while (pool_size - used >= 2 * HEADER_BYTES) begin
			rest = pool_size - used;
			i = 0;
			while (i + 1 < ORDER_SLOTS && i + 1 <= 20 && (64'd1 << (i + 1)) <= rest) i++;
			blk_ord[used / 32] = i;
			blk_free[used / 32] = 1;
			blk_head[used / 32] = 1;
			push_free(i, int'(used / 32));
			used += 64'd1 << i;
		end
		held_bytes = 0;
	endfunction

	function automatic res_t make_res(logic [1:0] st, longint off, longint use_b);
		res_t r;
		r.status   = st;
		r.granted  = off[19:0];
		r.usable   = use_b[20:0];
		r.reserved = held_bytes[20:0];
		return r;
	endfunction

	function automatic res_t grant_block(longint req);
		longint need;
		int n;
		int m;
		int a;
		int b;
		int u;
		need = req + HEADER_BYTES;
		if (need < 2 * HEADER_BYTES) need = 2 * HEADER_BYTES;
		n = 0;
		while (n < 63 && (64'd1 << n) < need) n++;
		if (n >= ORDER_SLOTS || n > 20) return make_res(ST_FAIL, 0, 0);
		m = n;
		while (m < ORDER_SLOTS && list_len[m] == 0) m++;
		if (m >= ORDER_SLOTS) return make_res(ST_FAIL, 0, 0);
		// Split down to the wanted order; the lower half ends up on top.
		while (m > n) begin
			a = list_top[m];
			if (a >= UNITS) return make_res(ST_FAIL, 0, 0);
			unlink(m, a);
			m--;
			b = a + int'((64'd1 << m) / 32);
			if (b < UNITS) begin
				blk_ord[b] = m; blk_free[b] = 1; blk_head[b] = 1;
				push_free(m, b);
			end
			blk_ord[a] = m;
			push_free(m, a);
		end
		u = list_top[n];
		if (u >= UNITS) return make_res(ST_FAIL, 0, 0);
		unlink(n, u);
		blk_free[u] = 0;
		held_bytes += 64'd1 << n;
		return make_res(ST_OK, longint'(u) * 32 + HEADER_BYTES, (64'd1 << n) - HEADER_BYTES);
	endfunction

	function automatic res_t release_block(longint ptr);
		int u;
		int k;
		int bu;
		longint s;
		longint here;
		longint bo;
		if (ptr >= pool_size || ptr < HEADER_BYTES || (ptr - HEADER_BYTES) % 32 != 0)
			return make_res(ST_REJECT, 0, 0);
		u = int'((ptr - HEADER_BYTES) / 32);
		if (u >= UNITS || !blk_head[u] || blk_free[u] || blk_ord[u] >= ORDER_SLOTS)
			return make_res(ST_REJECT, 0, 0);
		k = blk_ord[u];
		held_bytes = held_bytes >= (64'd1 << k) ? held_bytes - (64'd1 << k) : 0;
		// Merge with the equal free buddy while one exists inside the pool.
		while (k + 1 < ORDER_SLOTS && k + 1 <= 20) begin
			s = 64'd1 << k;
			here = longint'(u) * 32;
			if (here % (2 * s) == 0) begin
				bo = here + s;
				if (bo + s > pool_size) break;
			end else begin
				if (here < s) break;
				bo = here - s;
			end
			bu = int'(bo / 32);
			if (bu >= UNITS || !blk_head[bu] || !blk_free[bu] || blk_ord[bu] != k) break;
			unlink(k, bu);
			if (bo < here) begin
				blk_head[u] = 0;
				u = bu;
			end else begin
				blk_head[bu] = 0;
				blk_free[bu] = 0;
			end
			k++;
			blk_ord[u] = k;
		end
		blk_ord[u] = k;
		blk_free[u] = 1;
		blk_head[u] = 1;
		push_free(k, u);
		return make_res(ST_OK, 0, 0);
	endfunction

	task automatic report(string what);
		$display("[%0t] mismatch: %s", $realtime, what);
		failures++;
	endtask

	initial failures = 0;
	assign pending = awaited.size();

	always @(posedge clk or negedge arst_n) begin
		res_t want;
		res_t got;
		if (!arst_n) begin
			awaited.delete();
			pool_size = POOL_MAX;
			recarve();
		end else begin
			if (cfg_we) begin
				pool_size = cfg_wdata > POOL_MAX ? POOL_MAX : cfg_wdata;
				recarve();
			end
			if (s_tvalid && s_tready) begin
				if (s_tuser[0] == MODE_ALLOC) awaited.push_back(grant_block(s_tdata[20:0]));
				else awaited.push_back(release_block(s_tdata[41:21]));
			end
			if (m_tvalid && m_tready) begin
				got.status   = m_tuser;
				got.granted  = m_tdata[19:0];
				got.usable   = m_tdata[40:20];
				got.reserved = m_tdata[61:41];
				if (awaited.size() == 0) begin
					report("result with nothing expected");
				end else begin
					want = awaited.pop_front();
					if (got.status !== want.status)
						report($sformatf("status %0d, expected %0d", got.status, want.status));
					if (got.granted !== want.granted)
						report($sformatf("granted_offset %0d, expected %0d",
							got.granted, want.granted));
					if (got.usable !== want.usable)
						report($sformatf("usable_bytes %0d, expected %0d",
							got.usable, want.usable));
					if (got.reserved !== want.reserved)
						report($sformatf("reserved_total %0d, expected %0d",
							got.reserved, want.reserved));
				end
			end
		end
	end

endmodule

### tb/sv/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
	import bba_pkg::*;

	// A stall watchdog limit, long enough to cover the clearing pass.
	localparam int STALL_LIMIT = 200000;
	// Cycles allowed after the last result before touching the pool size.
	localparam int SETTLE = 80;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              cfg_we = 1'b0;
	logic [POOL_W-1:0] cfg_wdata = '0;
	logic              s_tvalid = 1'b0;
	logic              s_tready;
	logic [47:0]       s_tdata = '0;
	logic [0:0]        s_tuser = '0;
	logic              m_tvalid;
	logic              m_tready = 1'b0;
	logic [63:0]       m_tdata;
	logic [1:0]        m_tuser;
	int                pending;
	int                failures;

	// Offsets of blocks that are believed allocated, learned from results.
	int                live_ptrs[$];
	logic              modes_sent[$];
	bit                no_gaps = 0;
	int                stall_cycles = 0;
	int                n_grant = 0;
	int                n_refused = 0;
	int                n_released = 0;
	int                n_rejected = 0;
	int                n_pool_writes = 0;

	always #6 clk = ~clk;

	buddy_block_allocator dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
	);

	bba_checker u_checker (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.pending(pending), .failures(failures)
	);

	// Sends one item. Each call starts and ends on a falling edge, so valid is
	// either held across back-to-back items or lowered once for a gap.
	task automatic send_item(logic mode, int unsigned req, int unsigned ptr);
		int gap;
		gap = no_gaps ? 0 : $urandom_range(0, 12);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= mode;
		s_tdata  <= {6'b0, ptr[20:0], req[20:0]};
		do @(posedge clk); while (!s_tready);
		modes_sent.push_back(mode);
		@(negedge clk);
	endtask

	task automatic alloc(int unsigned req);
		send_item(MODE_ALLOC, req, $urandom_range(0, 2097151));
	endtask

	task automatic release_ptr(int unsigned ptr);
		send_item(MODE_FREE, $urandom_range(0, 2097151), ptr);
	endtask

	// Drains all results, then lets the block finish any internal work.
	task automatic drain();
		s_tvalid <= 1'b0;
		@(negedge clk);
		while (pending != 0) @(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic write_pool(int unsigned bytes);
		drain();
		cfg_we    <= 1'b1;
		cfg_wdata <= bytes[20:0];
		@(negedge clk);
		cfg_we <= 1'b0;
		live_ptrs.delete();
		n_pool_writes++;
	endtask

	// Mostly well-formed traffic: allocations sized to the pool and frees of
	// live blocks, with some oversized requests and bogus or repeated frees.
	task automatic random_traffic(int count, int unsigned pool);
		int pick;
		int idx;
		int unsigned p;
		int unsigned cap;
		cap = pool > 64 ? pool / 4 : 16;
		for (int i = 0; i < count; i++) begin
			if (i % 60 == 0) no_gaps = ($urandom_range(0, 3) == 0);
			pick = $urandom_range(0, 99);
			if (pick < 45) begin
				alloc($urandom_range(0, 3) == 0 ? $urandom_range(0, 64) : $urandom_range(0, cap));
			end else if (pick < 85 && live_ptrs.size() > 0) begin
				idx = $urandom_range(0, live_ptrs.size() - 1);
				p = live_ptrs[idx];
				// Sometimes keep the entry so that a later free repeats it.
				if ($urandom_range(0, 9) != 0) live_ptrs.delete(idx);
				release_ptr(p);
			end else if (pick < 92) begin
				alloc($urandom_range(0, 2097151));
			end else if (pick < 96) begin
				release_ptr(HEADER_BYTES + 32 * $urandom_range(0, 32767));
			end else begin
				release_ptr($urandom_range(0, 2097151));
			end
		end
	endtask

	// The receiver stalls per item, with stretches of full readiness.
	initial begin
		int gap;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			gap = no_gaps ? 0 : $urandom_range(0, 12);
			if (gap > 0) begin
				m_tready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
			if (modes_sent.size() > 0) begin
				if (modes_sent.pop_front() == MODE_ALLOC) begin
					if (m_tuser == ST_OK) begin
						live_ptrs.push_back(int'(m_tdata[19:0]));
						n_grant++;
					end else begin
						n_refused++;
					end
				end else begin
					if (m_tuser == ST_OK) n_released++;
					else n_rejected++;
				end
			end
			@(negedge clk);
		end
	end

	// Ends the run if neither channel moves an item for too long.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= STALL_LIMIT) begin
			$display("Timeout: no item moved for %0d cycles", STALL_LIMIT);
			$display("Verification failed");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	initial begin
		int unsigned first;
		int unsigned sizes[6];
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed part on the full pool from reset.
		alloc(0);
		alloc(16);
		alloc(17);
		alloc(1048576);
		alloc(2097151);
		alloc(1048560);
		release_ptr(2097151);
		release_ptr(0);
		release_ptr(17);
		release_ptr(HEADER_BYTES + 32 * 4000);
		drain();
		first = live_ptrs[0];
		release_ptr(first);
		release_ptr(first);
		foreach (live_ptrs[i]) if (i > 0) release_ptr(live_ptrs[i]);
		live_ptrs.delete();
		alloc(1048560);
		drain();
		if (live_ptrs.size() > 0) release_ptr(live_ptrs.pop_front());
		random_traffic(300, 1048576);

		// Small and odd pool sizes, the clamp above the maximum, and back.
		sizes = '{32, 31, 2097151, 48 + 16, 1000, 100000};
		foreach (sizes[i]) begin
			write_pool(sizes[i]);
			alloc(0);
			alloc(16);
			alloc(17);
			random_traffic(i == 1 ? 40 : 190, sizes[i] > 1048576 ? 1048576 : sizes[i]);
		end
		write_pool(1048576);
		random_traffic(150, 1048576);
		drain();

		$display("Covered %0d granted and %0d refused allocations, %0d frees and %0d rejected",
			n_grant, n_refused, n_released, n_rejected);
		$display("frees, over %0d pool size writes.", n_pool_writes);
		if (failures == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
